FILE: sv/cti_pkg.sv
// Shared types and constants for the curve table linear interpolator.
// Used by cti_arith, cti_dp, cti_ctrl and curve_table_linear_interpolator.
`default_nettype none

package cti_pkg;

  // Input item command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register map (word index taken from paddr[2])
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // Fixed port widths
  localparam int DATA_BITS  = 32;
  localparam int INDEX_BITS = 10;
  localparam int CFG_BITS   = 11;
  localparam int ADDR_BITS  = 3;

  // Product / quotient register and the step counter that walks it
  localparam int ACC_BITS  = 64;
  localparam int STEP_BITS = 7;

  // Table read address source
  typedef enum logic [1:0] {
    RD_FIRST = 2'd0,
    RD_LAST  = 2'd1,
    RD_SCAN  = 2'd2
  } cti_rd_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic        wr_en;
    logic        load_query;
    cti_rd_sel_t rd_sel;
    logic        scan_clr;
    logic        cap_first;
    logic        save_prev;
    logic        set_oor;
    logic        set_exact;
    logic        arith_init;
    logic        mul_step;
    logic        div_step;
    logic        set_interp;
    logic        load_out;
  } cti_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic lt_first;
    logic q_lt_x;
    logic q_eq_x;
    logic q_gt_x;
  } cti_stat_t;

endpackage

`default_nettype wire

FILE: sv/cti_arith.sv
// Shift-add multiplier followed by a restoring divider sharing one 64-bit register.
// Depends on cti_pkg for ACC_BITS.
`default_nettype none

module cti_arith #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              init,
  input  wire logic                              mul_step,
  input  wire logic                              div_step,
  input  wire logic [VALUE_BITS-1:0]             mcand,
  input  wire logic [VALUE_BITS-1:0]             mplier,
  input  wire logic [VALUE_BITS-1:0]             divisor,
  output logic      [cti_pkg::ACC_BITS-1:0]      quot
);

  logic [cti_pkg::ACC_BITS-1:0] acc_r;
  logic [cti_pkg::ACC_BITS-1:0] mcand_r;
  logic [VALUE_BITS-1:0]        mplier_r;
  logic [VALUE_BITS-1:0]        rem_r;
  logic [VALUE_BITS-1:0]        div_r;
  logic [VALUE_BITS:0]          rem_sh;
  logic [VALUE_BITS:0]          rem_sub;
  logic                         qbit;

  // Trial subtraction for one quotient bit
  always_comb begin
    rem_sh  = {rem_r, acc_r[cti_pkg::ACC_BITS-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    qbit    = (rem_sh >= {1'b0, div_r});
  end

  // Multiply one multiplier bit per cycle, then divide one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (init) begin
      acc_r    <= '0;
      mcand_r  <= cti_pkg::ACC_BITS'(mcand);
      mplier_r <= mplier;
      rem_r    <= '0;
      div_r    <= divisor;
    end else if (mul_step) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[cti_pkg::ACC_BITS-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[VALUE_BITS-1:1]};
    end else if (div_step) begin
      acc_r <= {acc_r[cti_pkg::ACC_BITS-2:0], qbit};
      rem_r <= qbit ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
    end
  end

  assign quot = acc_r;

endmodule

`default_nettype wire

FILE: sv/cti_dp.sv
// Datapath: abscissa and ordinate memories, scan address, comparators,
// result and output registers. Depends on cti_pkg and cti_arith.
`default_nettype none

module cti_dp #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic                                 clk,
  input  wire cti_pkg::cti_cmd_t                    cmd,
  output cti_pkg::cti_stat_t                        stat,
  input  wire logic [cti_pkg::CFG_BITS-1:0]         entry_count,
  input  wire logic [cti_pkg::INDEX_BITS-1:0]       in_entry_index,
  input  wire logic [cti_pkg::DATA_BITS-1:0]        in_entry_abscissa,
  input  wire logic [cti_pkg::DATA_BITS-1:0]        in_entry_ordinate,
  input  wire logic [cti_pkg::DATA_BITS-1:0]        in_query_point,
  output logic      [cti_pkg::DATA_BITS-1:0]        out_value,
  output logic                                      out_in_range
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [VALUE_BITS-1:0] abs_mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] ord_mem [TABLE_DEPTH];

  logic [VALUE_BITS-1:0]          rd_x_r;
  logic [VALUE_BITS-1:0]          rd_y_r;
  logic [VALUE_BITS-1:0]          q_r;
  logic [VALUE_BITS-1:0]          xp_r;
  logic [VALUE_BITS-1:0]          yp_r;
  logic                           neg_r;
  logic                           lt_first_r;
  logic [AW-1:0]                  scan_r;
  logic [cti_pkg::DATA_BITS-1:0]  res_value_r;
  logic                           res_in_range_r;
  logic [cti_pkg::DATA_BITS-1:0]  out_value_r;
  logic                           out_in_range_r;

  logic [AW-1:0]                  last_addr;
  logic [AW-1:0]                  rd_addr;
  logic                           wr_ok;
  logic [VALUE_BITS-1:0]          dy;
  logic [cti_pkg::ACC_BITS-1:0]   quot;
  logic [cti_pkg::DATA_BITS-1:0]  yp_low;
  logic [cti_pkg::DATA_BITS-1:0]  interp;

  // Last entry in use, with the count clamped to the table
  always_comb begin
    priority if (entry_count == '0) begin
      last_addr = '0;
    end else if (32'(entry_count) > TABLE_DEPTH) begin
      last_addr = AW'(TABLE_DEPTH - 1);
    end else begin
      last_addr = AW'(entry_count - cti_pkg::CFG_BITS'(1));
    end
  end

  // Pick the read address
  always_comb begin
    unique case (cmd.rd_sel)
      cti_pkg::RD_FIRST: rd_addr = '0;
      cti_pkg::RD_LAST:  rd_addr = last_addr;
      cti_pkg::RD_SCAN:  rd_addr = scan_r;
      default:           rd_addr = scan_r;
    endcase
  end

  assign wr_ok = (32'(in_entry_index) < TABLE_DEPTH);

  // Table memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      abs_mem[AW'(in_entry_index)] <= VALUE_BITS'(in_entry_abscissa);
      ord_mem[AW'(in_entry_index)] <= VALUE_BITS'(in_entry_ordinate);
    end
    rd_x_r <= abs_mem[rd_addr];
    rd_y_r <= ord_mem[rd_addr];
  end

  // Comparisons against the entry just read
  always_comb begin
    stat.lt_first = lt_first_r;
    stat.q_lt_x   = (q_r < rd_x_r);
    stat.q_eq_x   = (q_r == rd_x_r);
    stat.q_gt_x   = (q_r > rd_x_r);
  end

  assign dy = (rd_y_r >= yp_r) ? (rd_y_r - yp_r) : (yp_r - rd_y_r);

  cti_arith #(
    .VALUE_BITS (VALUE_BITS)
  ) u_arith (
    .clk      (clk),
    .init     (cmd.arith_init),
    .mul_step (cmd.mul_step),
    .div_step (cmd.div_step),
    .mcand    (q_r - xp_r),
    .mplier   (dy),
    .divisor  (rd_x_r - xp_r),
    .quot     (quot)
  );

  // Apply the truncated step to the previous ordinate
  always_comb begin
    yp_low = cti_pkg::DATA_BITS'(yp_r);
    interp = neg_r ? (yp_low - quot[cti_pkg::DATA_BITS-1:0])
                   : (yp_low + quot[cti_pkg::DATA_BITS-1:0]);
  end

  // Query, scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_r <= VALUE_BITS'(in_query_point);
    end
    if (cmd.cap_first) begin
      lt_first_r <= (q_r < rd_x_r);
    end
    if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.rd_sel == cti_pkg::RD_SCAN) begin
      scan_r <= scan_r + AW'(1);
    end
    if (cmd.save_prev) begin
      xp_r <= rd_x_r;
      yp_r <= rd_y_r;
    end
    if (cmd.arith_init) begin
      neg_r <= (rd_y_r < yp_r);
    end
    priority if (cmd.set_oor) begin
      res_value_r    <= '0;
      res_in_range_r <= 1'b0;
    end else if (cmd.set_exact) begin
      res_value_r    <= cti_pkg::DATA_BITS'(rd_y_r);
      res_in_range_r <= 1'b1;
    end else if (cmd.set_interp) begin
      res_value_r    <= interp;
      res_in_range_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_value_r    <= res_value_r;
      out_in_range_r <= res_in_range_r;
    end
  end

  assign out_value    = out_value_r;
  assign out_in_range = out_in_range_r;

endmodule

`default_nettype wire

FILE: sv/cti_ctrl.sv
// Controller state machine: range check, table scan, multiply and divide
// sequencing, output handshake. Depends on cti_pkg.
`default_nettype none

module cti_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_cmd,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire cti_pkg::cti_stat_t stat,
  output cti_pkg::cti_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_CHECK,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        pend_r, pend_nxt;
  logic [cti_pkg::STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                        accept;
  logic                        out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    cmd           = '0;
    cmd.rd_sel    = cti_pkg::RD_SCAN;

    unique case (state_r)
      S_IDLE: begin
        cmd.rd_sel = cti_pkg::RD_FIRST;
        if (accept) begin
          if (in_cmd == cti_pkg::CMD_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            state_nxt      = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        cmd.rd_sel = cti_pkg::RD_FIRST;
        state_nxt  = S_LAST;
      end
      S_LAST: begin
        // first entry is on the read port now
        cmd.rd_sel    = cti_pkg::RD_LAST;
        cmd.cap_first = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        // last entry is on the read port now
        cmd.rd_sel = cti_pkg::RD_LAST;
        pend_nxt   = 1'b0;
        if (stat.lt_first || stat.q_gt_x) begin
          cmd.set_oor = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read per cycle, judge the entry read the cycle before
        cmd.rd_sel = cti_pkg::RD_SCAN;
        pend_nxt   = 1'b1;
        if (pend_r) begin
          priority if (stat.q_eq_x) begin
            cmd.set_exact = 1'b1;
            pend_nxt      = 1'b0;
            state_nxt     = S_FIN;
          end else if (stat.q_lt_x) begin
            cmd.arith_init = 1'b1;
            cnt_nxt        = cti_pkg::STEP_BITS'(VALUE_BITS - 1);
            state_nxt      = S_MUL;
          end else begin
            cmd.save_prev = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = cti_pkg::STEP_BITS'(cti_pkg::ACC_BITS - 1);
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r - cti_pkg::STEP_BITS'(1);
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          // quotient is complete after this edge; mark it for the result register
          state_nxt = S_FIN;
          pend_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r - cti_pkg::STEP_BITS'(1);
        end
      end
      S_FIN: begin
        // interpolated result lands in the result register on the first cycle here
        if (pend_r) begin
          cmd.set_interp = 1'b1;
          pend_nxt       = 1'b0;
        end else if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/curve_table_linear_interpolator.sv
// Top level of the curve table linear interpolator: configuration register,
// controller and datapath. Depends on cti_pkg, cti_ctrl and cti_dp.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer. A load
//   item (in_cmd = 0) writes one abscissa/ordinate pair and yields no result;
//   the controller stays idle for it. A query item (in_cmd = 1) yields one
//   result on the output channel (out_valid / out_stall).
//   A query outside the first-to-last abscissa is settled once the first and
//   last entries are read, without a scan; an exact hit at entry k ends the
//   scan there. An in-range query scans the table from entry 0, one entry per
//   cycle, and if no entry matches exactly runs a shift-add multiply over the
//   VALUE_BITS multiplier bits and a restoring divide over the 64 quotient
//   bits on one shared register.
//   One item is worked on at a time; in_stall is high while a query runs.
//   The result sits in an output register; loads and a new query are taken
//   while it waits, and a finished query holds until the register drains.
//   Reset (rst_n low, synchronous) clears the controller and sets entry_count
//   to 1; table contents are not cleared and must be loaded before use.
//   entry_count sits at byte address 0 of the APB-style port.
`default_nettype none

module curve_table_linear_interpolator #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_cmd,
  input  wire logic [cti_pkg::INDEX_BITS-1:0]        in_entry_index,
  input  wire logic [cti_pkg::DATA_BITS-1:0]         in_entry_abscissa,
  input  wire logic [cti_pkg::DATA_BITS-1:0]         in_entry_ordinate,
  input  wire logic [cti_pkg::DATA_BITS-1:0]         in_query_point,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic      [cti_pkg::DATA_BITS-1:0]         out_value,
  output logic                                       out_in_range,
  // configuration port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [cti_pkg::ADDR_BITS-1:0]         paddr,
  input  wire logic [cti_pkg::DATA_BITS-1:0]         pwdata,
  output logic      [cti_pkg::DATA_BITS-1:0]         prdata,
  output logic                                       pready
);

  logic [cti_pkg::CFG_BITS-1:0] entry_count_r;
  logic                         reg_sel;
  cti_pkg::cti_cmd_t            cmd;
  cti_pkg::cti_stat_t           stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == cti_pkg::REG_ENTRY_COUNT);

  // Configuration register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= cti_pkg::CFG_BITS'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      entry_count_r <= pwdata[cti_pkg::CFG_BITS-1:0];
    end
  end

  // Register read back
  assign prdata = reg_sel ? cti_pkg::DATA_BITS'(entry_count_r) : '0;

  cti_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cti_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .stat              (stat),
    .entry_count       (entry_count_r),
    .in_entry_index    (in_entry_index),
    .in_entry_abscissa (in_entry_abscissa),
    .in_entry_ordinate (in_entry_ordinate),
    .in_query_point    (in_query_point),
    .out_value         (out_value),
    .out_in_range      (out_in_range)
  );

endmodule

`default_nettype wire
